/* hw/rtl/alpha_grid_search_calibrator_top_defines.svh */
// Assertion macros for the gain sweep calibrator.
// Used by modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef ALPHA_GRID_SEARCH_CALIBRATOR_TOP_DEFINES_SVH
`define ALPHA_GRID_SEARCH_CALIBRATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define GSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GSC_ASSERT_IMP(lbl, ante, cons, msg)
`define GSC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/gsc_pkg.sv */
// Shared types and constants for the gain sweep calibrator.
// No dependencies; imported by every other file but the assertion macro header.
`timescale 1ns / 1ps

package gsc_pkg;

	localparam int GAIN_WIDTH = 32;
	localparam int DATA_W     = 32;
	localparam int CFG_IDX_W  = 2;

	typedef logic [GAIN_WIDTH-1:0] gain_t;
	typedef logic [DATA_W-1:0]     data_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [1:0]            req_code_t;

	localparam data_t SCORE_NONE = '1;

	// configuration register indexes
	localparam cfg_idx_t CFG_SWEEP_MIN  = 2'd0;
	localparam cfg_idx_t CFG_SWEEP_MAX  = 2'd1;
	localparam cfg_idx_t CFG_SWEEP_STEP = 2'd2;

	// request codes
	localparam req_code_t REQ_START  = 2'd0;
	localparam req_code_t REQ_REPORT = 2'd1;
	localparam req_code_t REQ_POLL   = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_TUNE   = 2'd1,
		PH_STREAM = 2'd2,
		PH_FAULT  = 2'd3
	} phase_t;

	typedef struct packed {
		gain_t sweep_min;
		gain_t sweep_max;
		gain_t sweep_step;
	} cfg_t;

	typedef struct packed {
		req_code_t req_type;
		logic      meas_ok;
		data_t     flip_count;
		data_t     fault_word;
	} req_item_t;

	typedef struct packed {
		phase_t phase;
		logic   apply_gain;
		data_t  gain_value;
		logic   clear_request;
		data_t  best_gain;
		data_t  best_score;
		logic   best_found;
	} res_item_t;

endpackage

/* hw/rtl/gsc_if.sv */
// Valid/ready channel interfaces: request items in, result items out.
// Depends on gsc_pkg.
`timescale 1ns / 1ps

interface gsc_req_if;
	import gsc_pkg::*;

	logic      valid;
	logic      ready;
	req_code_t req_type;
	logic      meas_ok;
	data_t     flip_count;
	data_t     fault_word;

	modport source (output valid, req_type, meas_ok, flip_count, fault_word, input ready);
	modport sink   (input valid, req_type, meas_ok, flip_count, fault_word, output ready);
endinterface

interface gsc_res_if;
	import gsc_pkg::*;

	logic   valid;
	logic   ready;
	phase_t phase;
	logic   apply_gain;
	data_t  gain_value;
	logic   clear_request;
	data_t  best_gain;
	data_t  best_score;
	logic   best_found;

	modport source (output valid, phase, apply_gain, gain_value, clear_request, best_gain,
		best_score, best_found, input ready);
	modport sink   (input valid, phase, apply_gain, gain_value, clear_request, best_gain,
		best_score, best_found, output ready);
endinterface

/* hw/rtl/gsc_cfg.sv */
// Sweep configuration registers (min, max, step) behind a plain write port.
// Depends on gsc_pkg.
`timescale 1ns / 1ps

module gsc_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  gsc_pkg::cfg_idx_t cfg_index,
	input  gsc_pkg::data_t    cfg_data,
	output gsc_pkg::cfg_t     cfg
);
	import gsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sweep_min  <= '0;
			cfg_q.sweep_max  <= GAIN_WIDTH'(255);
			cfg_q.sweep_step <= GAIN_WIDTH'(1);
		end else if (cfg_we) begin
			// only the low gain bits are kept; GAIN_WIDTH equals DATA_W, so that is the whole word
			unique case (cfg_index)
				CFG_SWEEP_MIN:  cfg_q.sweep_min  <= cfg_data[GAIN_WIDTH-1:0];
				CFG_SWEEP_MAX:  cfg_q.sweep_max  <= cfg_data[GAIN_WIDTH-1:0];
				CFG_SWEEP_STEP: cfg_q.sweep_step <= cfg_data[GAIN_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/gsc_engine.sv */
// Sweep state (phase, current gain, best gain/score) and the per-item update.
// Depends on gsc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "alpha_grid_search_calibrator_top_defines.svh"

module gsc_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  gsc_pkg::req_item_t item,
	input  gsc_pkg::cfg_t      cfg,
	output gsc_pkg::res_item_t res
);
	import gsc_pkg::*;

	phase_t phase_q, phase_d;
	gain_t  cur_q, cur_d;
	gain_t  best_gain_q, best_gain_d;
	data_t  best_score_q, best_score_d;
	logic   best_found_q, best_found_d;

	gain_t                step_eff;
	logic [GAIN_WIDTH:0]  next_sum;
	logic                 sweep_end;
	logic                 beat;
	logic                 apply;
	gain_t                value;
	logic                 clear;

	always_comb begin
		step_eff = (cfg.sweep_step == '0) ? GAIN_WIDTH'(1) : cfg.sweep_step;
		// one extra bit: past max also covers leaving the gain width, since max fits in it
		next_sum  = {1'b0, cur_q} + {1'b0, step_eff};
		sweep_end = next_sum > {1'b0, cfg.sweep_max};
		beat      = item.meas_ok && (item.flip_count < best_score_q);

		phase_d      = phase_q;
		cur_d        = cur_q;
		best_gain_d  = best_gain_q;
		best_score_d = best_score_q;
		best_found_d = best_found_q;
		apply        = 1'b0;
		value        = '0;
		clear        = 1'b0;

		unique case (item.req_type)
			REQ_START: begin
				if (phase_q != PH_FAULT) begin
					clear        = 1'b1;
					best_gain_d  = cfg.sweep_min;
					best_score_d = SCORE_NONE;
					best_found_d = 1'b0;
					cur_d        = cfg.sweep_min;
					if (cfg.sweep_min > cfg.sweep_max) begin
						phase_d = PH_FAULT;
					end else begin
						phase_d = PH_TUNE;
						apply   = 1'b1;
						value   = cfg.sweep_min;
					end
				end
			end
			REQ_REPORT: begin
				if (phase_q == PH_TUNE) begin
					if (beat) begin
						best_gain_d  = cur_q;
						best_score_d = item.flip_count;
						best_found_d = 1'b1;
					end
					if (sweep_end) begin
						if (best_found_d) begin
							phase_d = PH_STREAM;
							apply   = 1'b1;
							value   = best_gain_d;
						end else begin
							phase_d = PH_FAULT;
						end
					end else begin
						cur_d = next_sum[GAIN_WIDTH-1:0];
						apply = 1'b1;
						value = next_sum[GAIN_WIDTH-1:0];
					end
				end
			end
			REQ_POLL: begin
				if (phase_q == PH_STREAM && item.fault_word != '0) begin
					phase_d = PH_FAULT;
				end
			end
			default: ;
		endcase

		res.phase         = phase_d;
		res.apply_gain    = apply;
		res.gain_value    = DATA_W'(value);
		res.clear_request = clear;
		res.best_gain     = DATA_W'(best_gain_d);
		res.best_score    = best_score_d;
		res.best_found    = best_found_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			cur_q        <= '0;
			best_gain_q  <= '0;
			best_score_q <= SCORE_NONE;
			best_found_q <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_d;
			cur_q        <= cur_d;
			best_gain_q  <= best_gain_d;
			best_score_q <= best_score_d;
			best_found_q <= best_found_d;
		end
	end

	`GSC_ASSERT_IMP(a_score_none, !best_found_q, best_score_q == SCORE_NONE, "score set without a valid measurement")
	`GSC_ASSERT_NXT(a_fault_sticky, phase_q == PH_FAULT, phase_q == PH_FAULT, "left fault phase")
	`GSC_ASSERT_IMP(a_stream_best, fire && res.apply_gain && res.phase == PH_STREAM, res.gain_value == res.best_gain, "stream entry did not apply best gain")
	`GSC_ASSERT_IMP(a_clear_resets, fire && res.clear_request, !res.best_found && res.best_score == SCORE_NONE, "start did not reset best")

endmodule

/* hw/rtl/alpha_grid_search_calibrator_top.sv */
// Gain sweep calibrator, top level: item input register, engine, result register.
// Depends on gsc_pkg, gsc_if, gsc_cfg and gsc_engine.
// The block takes one item per clock cycle unless the output stalls, and returns
// one result item for each: the item is registered in the input register, the
// sweep state is updated from it in one pass of compare-and-add logic, and the
// result lands in an output register. A result waiting at the output that is
// not taken holds the item in the input register, which then stops the next item.
// The sweep registers are written through the plain write port and apply from the
// next item on.
`timescale 1ns / 1ps

module alpha_grid_search_calibrator_top (
	input  logic              clk,
	input  logic              arst_n,
	gsc_req_if.sink           req,
	gsc_res_if.source         res,
	input  logic              cfg_we,
	input  gsc_pkg::cfg_idx_t cfg_index,
	input  gsc_pkg::data_t    cfg_data
);
	import gsc_pkg::*;

	cfg_t      cfg;
	logic      valid_s1;
	req_item_t item_s1;
	logic      out_valid_q;
	res_item_t res_q;
	res_item_t res_d;
	logic      advance;

	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	gsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gsc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type   <= req.req_type;
			item_s1.meas_ok    <= req.meas_ok;
			item_s1.flip_count <= req.flip_count;
			item_s1.fault_word <= req.fault_word;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.phase         = res_q.phase;
	assign res.apply_gain    = res_q.apply_gain;
	assign res.gain_value    = res_q.gain_value;
	assign res.clear_request = res_q.clear_request;
	assign res.best_gain     = res_q.best_gain;
	assign res.best_score    = res_q.best_score;
	assign res.best_found    = res_q.best_found;

endmodule
